>>> hw/rtl/mandelbrot_escape_time_pixel_unit_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// Check sampled on the rising clock edge, ignored while reset is asserted
`define MBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on every rising clock edge, reset included
`define MBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit package
// Shared types, register codes and reset values for the pixel unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ITER  = 3'd5;

    // Register reset values
    localparam logic [31:0] RST_X_START  = 32'hE000_0000;
    localparam logic [31:0] RST_Y_START  = 32'hE800_0000;
    localparam logic [31:0] RST_STEP_X   = 32'd196656;
    localparam logic [31:0] RST_STEP_Y   = 32'd196656;
    localparam logic [15:0] RST_MAX_ITER = 16'd256;

    // Result field widths and the fixed outside value
    localparam int          PIXEL_W       = 16;
    localparam int          USED_W        = 16;
    localparam int          M_TDATA_W     = PIXEL_W + USED_W;
    localparam logic [15:0] OUTSIDE_VALUE = 16'd100;

    // Coordinate and z widths
    localparam int C_W = 32;
    localparam int Z_W = 33;

    typedef struct packed {
        logic signed [C_W-1:0] x_start;
        logic signed [C_W-1:0] y_start;
        logic signed [C_W-1:0] step_x;
        logic signed [C_W-1:0] step_y;
        logic [15:0]           max_iterations;
        logic                  color_by_iterations;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic coord_mul;
        logic coord_add;
        logic iter_mul;
        logic iter_upd;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic limit_zero;
        logic escape;
        logic at_limit;
    } dp_sts_t;

endpackage

>>> hw/rtl/mbe_cfg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit configuration registers
// Decodes register writes and holds the view window and iteration settings.
// ----------------------------------------------------------------------------
module mbe_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbe_pkg::cfg_t                  cfg
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;

    // Writes are always accepted and registered
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                mbe_pkg::REG_X_START:    cfg_next.x_start = $signed(cfg_data);
                mbe_pkg::REG_Y_START:    cfg_next.y_start = $signed(cfg_data);
                mbe_pkg::REG_STEP_X:     cfg_next.step_x  = $signed(cfg_data);
                mbe_pkg::REG_STEP_Y:     cfg_next.step_y  = $signed(cfg_data);
                mbe_pkg::REG_MAX_ITER:   cfg_next.max_iterations = cfg_data[15:0];
                mbe_pkg::REG_COLOR_ITER: cfg_next.color_by_iterations = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_start             <= $signed(mbe_pkg::RST_X_START);
            cfg_reg.y_start             <= $signed(mbe_pkg::RST_Y_START);
            cfg_reg.step_x              <= $signed(mbe_pkg::RST_STEP_X);
            cfg_reg.step_y              <= $signed(mbe_pkg::RST_STEP_Y);
            cfg_reg.max_iterations      <= mbe_pkg::RST_MAX_ITER;
            cfg_reg.color_by_iterations <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/mbe_dp.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit datapath
// Point mapping, the z = z*z + c step with escape test, and result register.
// ----------------------------------------------------------------------------
module mbe_dp #(
    parameter int INDEX_BITS = 12,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 16
) (
    input  logic                         aclk,
    input  mbe_pkg::cfg_t                cfg,
    input  mbe_pkg::dp_cmd_t             cmd,
    output mbe_pkg::dp_sts_t             sts,
    input  logic [INDEX_BITS-1:0]        column,
    input  logic [INDEX_BITS-1:0]        row,
    output logic [mbe_pkg::PIXEL_W-1:0]  pixel_value,
    output logic                         escaped,
    output logic [mbe_pkg::USED_W-1:0]   iterations_used
);

    localparam int C_W    = mbe_pkg::C_W;
    localparam int Z_W    = mbe_pkg::Z_W;
    localparam int CNT_W  = (ITER_BITS < 16) ? ITER_BITS : 16;
    localparam int CP_W   = INDEX_BITS + 1 + C_W;
    localparam int CS_W   = CP_W + 1;
    localparam int MAG_W  = Z_W - 1;
    localparam int PR_W   = 2 * MAG_W;
    localparam int SQ_W   = PR_W - FRAC_BITS;
    localparam int NX_W   = ((SQ_W > C_W) ? SQ_W : C_W) + 3;
    localparam int SUM_W  = ((SQ_W + 1) > (FRAC_BITS + 3)) ? (SQ_W + 1) : (FRAC_BITS + 3);

    localparam logic [SUM_W-1:0] THRESH = SUM_W'(4) << FRAC_BITS;
    localparam logic signed [NX_W-1:0] Z_MAX = $signed({{(NX_W-MAG_W){1'b0}}, {MAG_W{1'b1}}});
    localparam logic signed [NX_W-1:0] Z_MIN = -Z_MAX;
    localparam logic signed [CS_W-1:0] C_MAX = $signed({{(CS_W-C_W+1){1'b0}}, {(C_W-1){1'b1}}});
    localparam logic signed [CS_W-1:0] C_MIN = $signed({{(CS_W-C_W+1){1'b1}}, {(C_W-1){1'b0}}});

    logic [INDEX_BITS-1:0]   col_reg, col_next;
    logic [INDEX_BITS-1:0]   row_reg, row_next;
    logic signed [CP_W-1:0]  cprod_x_reg, cprod_x_next;
    logic signed [CP_W-1:0]  cprod_y_reg, cprod_y_next;
    logic signed [C_W-1:0]   cx_reg, cx_next;
    logic signed [C_W-1:0]   cy_reg, cy_next;
    logic signed [Z_W-1:0]   zx_reg, zx_next;
    logic signed [Z_W-1:0]   zy_reg, zy_next;
    logic [PR_W-1:0]         sq_x_reg, sq_x_next;
    logic [PR_W-1:0]         sq_y_reg, sq_y_next;
    logic [PR_W-1:0]         cr_reg, cr_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        it_reg, it_next;
    logic                    esc_reg, esc_next;
    logic [mbe_pkg::PIXEL_W-1:0] pixel_reg, pixel_next;
    logic                    escaped_reg, escaped_next;
    logic [mbe_pkg::USED_W-1:0]  used_reg, used_next;

    logic [CNT_W-1:0]        limit;
    logic [MAG_W-1:0]        ax, ay;
    logic signed [CS_W-1:0]  csum_x, csum_y;
    logic [SQ_W-1:0]         sx, sy, cr;
    logic [SUM_W-1:0]        sq_sum;
    logic signed [NX_W-1:0]  cross_term, nx, ny;
    logic [mbe_pkg::USED_W-1:0]  used_val;

    assign limit = cfg.max_iterations[CNT_W-1:0];

    // Magnitudes of z for the squaring multipliers
    assign ax = zx_reg[Z_W-1] ? MAG_W'(-zx_reg) : MAG_W'(zx_reg);
    assign ay = zy_reg[Z_W-1] ? MAG_W'(-zy_reg) : MAG_W'(zy_reg);

    // Point mapping sums
    assign csum_x = CS_W'($signed(cfg.x_start)) + CS_W'(cprod_x_reg);
    assign csum_y = CS_W'($signed(cfg.y_start)) + CS_W'(cprod_y_reg);

    // Scaled squares, cross term and escape sum
    assign sx     = sq_x_reg[PR_W-1:FRAC_BITS];
    assign sy     = sq_y_reg[PR_W-1:FRAC_BITS];
    assign cr     = cr_reg[PR_W-1:FRAC_BITS];
    assign sq_sum = SUM_W'(sx) + SUM_W'(sy);
    assign cross_term = neg_reg ? -$signed(NX_W'(cr)) : $signed(NX_W'(cr));
    assign nx     = $signed(NX_W'(sx)) - $signed(NX_W'(sy)) + NX_W'(cx_reg);
    assign ny     = cross_term + cross_term + NX_W'(cy_reg);

    assign sts.limit_zero = (limit == '0);
    assign sts.escape     = (sq_sum > THRESH);
    assign sts.at_limit   = (it_reg == limit);

    assign used_val = esc_reg ? mbe_pkg::USED_W'(it_reg) : mbe_pkg::USED_W'(limit);

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        cprod_x_next = cprod_x_reg;
        cprod_y_next = cprod_y_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        zx_next      = zx_reg;
        zy_next      = zy_reg;
        sq_x_next    = sq_x_reg;
        sq_y_next    = sq_y_reg;
        cr_next      = cr_reg;
        neg_next     = neg_reg;
        it_next      = it_reg;
        esc_next     = esc_reg;
        pixel_next   = pixel_reg;
        escaped_next = escaped_reg;
        used_next    = used_reg;

        // Take the pixel indexes
        if (cmd.capture) begin
            col_next = column;
            row_next = row;
        end

        // index * step
        if (cmd.coord_mul) begin
            cprod_x_next = $signed({1'b0, col_reg}) * $signed(cfg.step_x);
            cprod_y_next = $signed({1'b0, row_reg}) * $signed(cfg.step_y);
        end

        // start + product, saturated; z and step count start over
        if (cmd.coord_add) begin
            if (csum_x > C_MAX) begin
                cx_next = C_MAX[C_W-1:0];
            end else if (csum_x < C_MIN) begin
                cx_next = C_MIN[C_W-1:0];
            end else begin
                cx_next = csum_x[C_W-1:0];
            end
            if (csum_y > C_MAX) begin
                cy_next = C_MAX[C_W-1:0];
            end else if (csum_y < C_MIN) begin
                cy_next = C_MIN[C_W-1:0];
            end else begin
                cy_next = csum_y[C_W-1:0];
            end
            zx_next  = '0;
            zy_next  = '0;
            it_next  = CNT_W'(1);
            esc_next = 1'b0;
        end

        // Products of the magnitudes
        if (cmd.iter_mul) begin
            sq_x_next = PR_W'(ax) * PR_W'(ax);
            sq_y_next = PR_W'(ay) * PR_W'(ay);
            cr_next   = PR_W'(ax) * PR_W'(ay);
            neg_next  = zx_reg[Z_W-1] ^ zy_reg[Z_W-1];
        end

        // Next z, clamped; count the step unless this one ends the item
        if (cmd.iter_upd) begin
            if (nx > Z_MAX) begin
                zx_next = Z_MAX[Z_W-1:0];
            end else if (nx < Z_MIN) begin
                zx_next = Z_MIN[Z_W-1:0];
            end else begin
                zx_next = nx[Z_W-1:0];
            end
            if (ny > Z_MAX) begin
                zy_next = Z_MAX[Z_W-1:0];
            end else if (ny < Z_MIN) begin
                zy_next = Z_MIN[Z_W-1:0];
            end else begin
                zy_next = ny[Z_W-1:0];
            end
            esc_next = sts.escape;
            if (!sts.escape && !sts.at_limit) begin
                it_next = it_reg + CNT_W'(1);
            end
        end

        // Result register
        if (cmd.out_load) begin
            escaped_next = esc_reg;
            used_next    = used_val;
            if (!esc_reg) begin
                pixel_next = '0;
            end else if (cfg.color_by_iterations) begin
                pixel_next = used_val;
            end else begin
                pixel_next = mbe_pkg::OUTSIDE_VALUE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        cprod_x_reg <= cprod_x_next;
        cprod_y_reg <= cprod_y_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        zx_reg      <= zx_next;
        zy_reg      <= zy_next;
        sq_x_reg    <= sq_x_next;
        sq_y_reg    <= sq_y_next;
        cr_reg      <= cr_next;
        neg_reg     <= neg_next;
        it_reg      <= it_next;
        esc_reg     <= esc_next;
        pixel_reg   <= pixel_next;
        escaped_reg <= escaped_next;
        used_reg    <= used_next;
    end

    assign pixel_value     = pixel_reg;
    assign escaped         = escaped_reg;
    assign iterations_used = used_reg;

endmodule

>>> hw/rtl/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit controller
// Sequences point mapping, the iteration loop and the result hand-off.
// ----------------------------------------------------------------------------
module mbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mbe_pkg::dp_sts_t  sts,
    output mbe_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD_MUL,
        ST_COORD_ADD,
        ST_ITER_MUL,
        ST_ITER_UPD,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COORD_MUL;
                end
            end
            ST_COORD_MUL: begin
                cmd.coord_mul = 1'b1;
                state_next    = ST_COORD_ADD;
            end
            ST_COORD_ADD: begin
                cmd.coord_add = 1'b1;
                state_next    = sts.limit_zero ? ST_FINISH : ST_ITER_MUL;
            end
            ST_ITER_MUL: begin
                cmd.iter_mul = 1'b1;
                state_next   = ST_ITER_UPD;
            end
            ST_ITER_UPD: begin
                cmd.iter_upd = 1'b1;
                state_next   = (sts.escape || sts.at_limit) ? ST_FINISH : ST_ITER_MUL;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel unit
// Maps a pixel index to a point c and counts z = z*z + c steps until escape or the limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per pixel, column and row in s_tdata.
//   Result stream (m_*): pixel_value and iterations_used in m_tdata, the
//   escaped flag in m_tuser. One result per request, in order.
//   Config port (cfg_*): register index and data; cfg_ready is always high.
//   Write registers only while no request is in flight.
// Sequence:
//   Steps run: up to the escape step, or max_iterations if the point stays
//   inside, none when the limit is 0. Each step goes through the squaring
//   multipliers in two states: ST_ITER_MUL multiplies, ST_ITER_UPD adds,
//   clamps and tests. The result is loaded once the output register is free,
//   and the next request is taken after that.
//   One request is worked on at a time; s_tready is high only when idle.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the unit and restores the
//   default window and limit. A stalled result is held in the output
//   register; a finished request waits in ST_FINISH until the register is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit #(
    parameter int INDEX_BITS = 12,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 16,
    localparam int S_TDATA_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // column, row
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbe_pkg::M_TDATA_W-1:0]    m_tdata,   // pixel_value, iterations_used
    output logic                             m_tuser,   // escaped
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mbe_pkg::cfg_t                cfg;
    mbe_pkg::dp_cmd_t             cmd;
    mbe_pkg::dp_sts_t             sts;
    logic [mbe_pkg::PIXEL_W-1:0]  pixel_value;
    logic [mbe_pkg::USED_W-1:0]   iterations_used;

    mbe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbe_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_dp (
        .aclk            (aclk),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .column          (s_tdata[INDEX_BITS-1:0]),
        .row             (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
        .pixel_value     (pixel_value),
        .escaped         (m_tuser),
        .iterations_used (iterations_used)
    );

    assign m_tdata = {iterations_used, pixel_value};

endmodule

>>> hw/rtl/mbe_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel unit port checker
// Watches the top-level ports for result and sequencing rules.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_macros.svh"

module mbe_checker #(
    parameter int INDEX_BITS = 12,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 16,
    localparam int S_TDATA_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mbe_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // A stalled result holds still
    `MBE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One request at a time: input closes right after a request
    `MBE_ASSERT(a_one_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    // Inside gives 0; outside gives 100 or the escape step, never step 1
    `MBE_ASSERT(a_value_code, aclk, aresetn, m_tvalid |-> (m_tuser || m_tdata[15:0] == 16'd0) && (!m_tuser || ((m_tdata[15:0] == mbe_pkg::OUTSIDE_VALUE || m_tdata[15:0] == m_tdata[31:16]) && m_tdata[31:16] > 16'd1)), "inconsistent result fields")

    // Reset empties the output
    `MBE_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind mandelbrot_escape_time_pixel_unit mbe_checker #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
) u_mbe_checker (.*);
